FILE: rtl/uart_trx_pkg.sv
// Shared types and constants for the serial transceiver.
// Used by the front decoder, the tick queue, the back engine, the top level and the checker.
package uart_trx_pkg;

  // Default receive FIFO depth in bytes
  localparam int FIFO_DEPTH_DEF = 16;

  // Register reset values
  localparam logic [15:0] BIT_PERIOD_RST = 16'd104;
  localparam logic [3:0]  DATA_BITS_RST  = 4'd8;

  // Limits of the effective settings
  localparam logic [15:0] MIN_PERIOD = 16'd2;
  localparam logic [3:0]  MIN_BITS   = 4'd5;
  localparam logic [3:0]  MAX_BITS   = 4'd8;

  // Command codes on the input channel
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SEND  = 2'd1;
  localparam logic [1:0] CMD_POP   = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
  localparam logic [1:0] REG_DATA_BITS  = 2'd1;
  localparam logic [1:0] REG_PARITY_EN  = 2'd2;
  localparam logic [1:0] REG_TWO_STOP   = 2'd3;

  // One classified tick as it travels from front to back
  typedef struct packed {
    logic       send;
    logic       pop;
    logic       rx_line;
    logic [7:0] tx_data;
  } tick_t;

endpackage

FILE: rtl/uart_transceiver.sv
// Top level of the tick-driven serial transceiver: front decoder, tick queue, back engine.
// Depends on uart_trx_pkg, uart_trx_front, uart_trx_queue and uart_trx_back.
//
//   channel | ports                          | direction | item
//   in      | in_valid / in_stall            | into      | one serial tick with command
//   out     | out_valid / out_stall          | out of    | line levels and receive status
//   cfg     | cfg_we, cfg_index, cfg_wdata   | into      | one register write
//
// One tick is accepted per clock while in_stall is low; each result passes the front register,
// a queue slot and the result register in that order, computed in the back engine.
// Reset is synchronous and active low; no clearing pass is needed.
// A stall on the result side fills the 2-entry queue before in_stall rises.
module uart_transceiver #(
  parameter int FIFO_DEPTH = uart_trx_pkg::FIFO_DEPTH_DEF,
  parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_cmd,
  input  logic             in_rx_line,
  input  logic [7:0]       in_tx_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_tx_line,
  output logic             out_tx_busy,
  output logic [7:0]       out_rx_data,
  output logic             out_rx_data_valid,
  output logic [CNT_W-1:0] out_rx_count,
  output logic             out_parity_error,
  output logic             out_overflow
);

  logic                fq_valid;
  logic                fq_full;
  uart_trx_pkg::tick_t fq_item;
  logic                bq_valid;
  logic                bq_take;
  uart_trx_pkg::tick_t bq_item;

  // Accept and classify ticks
  uart_trx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_rx_line (in_rx_line),
    .in_tx_data (in_tx_data),
    .fq_valid   (fq_valid),
    .fq_full    (fq_full),
    .fq_item    (fq_item)
  );

  // Decouple front and back
  uart_trx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .full     (fq_full),
    .wr_item  (fq_item),
    .rd_valid (bq_valid),
    .rd_take  (bq_take),
    .rd_item  (bq_item)
  );

  // Run the receiver, FIFO and transmitter one tick at a time
  uart_trx_back #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .bq_valid          (bq_valid),
    .bq_take           (bq_take),
    .bq_item           (bq_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tx_line       (out_tx_line),
    .out_tx_busy       (out_tx_busy),
    .out_rx_data       (out_rx_data),
    .out_rx_data_valid (out_rx_data_valid),
    .out_rx_count      (out_rx_count),
    .out_parity_error  (out_parity_error),
    .out_overflow      (out_overflow)
  );

endmodule

FILE: rtl/uart_trx_front.sv
// Front end: accepts ticks, decodes the command and hands them to the queue.
// Depends on uart_trx_pkg for the command codes and the tick_t item type.
module uart_trx_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic                 in_rx_line,
  input  logic [7:0]           in_tx_data,
  output logic                 fq_valid,
  input  logic                 fq_full,
  output uart_trx_pkg::tick_t  fq_item
);

  logic                valid_r;
  uart_trx_pkg::tick_t item_r;
  uart_trx_pkg::tick_t item_nxt;
  logic                take;

  // Hold the item while the queue is full
  assign in_stall = valid_r && fq_full;
  assign take     = in_valid && !in_stall;

  // Classify the command
  always_comb begin
    item_nxt.send    = 1'b0;
    item_nxt.pop     = 1'b0;
    item_nxt.rx_line = in_rx_line;
    item_nxt.tx_data = in_tx_data;
    case (in_cmd)
      uart_trx_pkg::CMD_SEND: item_nxt.send = 1'b1;
      uart_trx_pkg::CMD_POP:  item_nxt.pop  = 1'b1;
      uart_trx_pkg::CMD_TICK, uart_trx_pkg::CMD_SPARE: ;
      default: ;
    endcase
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (!fq_full) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign fq_valid = valid_r;
  assign fq_item  = item_r;

endmodule

FILE: rtl/uart_trx_queue.sv
// Two-entry queue of decoded ticks between the front end and the back engine.
// Depends on uart_trx_pkg for the tick_t item type.
module uart_trx_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 full,
  input  uart_trx_pkg::tick_t  wr_item,
  output logic                 rd_valid,
  input  logic                 rd_take,
  output uart_trx_pkg::tick_t  rd_item
);

  uart_trx_pkg::tick_t slot_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          count_r;
  logic                push;
  logic                pull;

  assign full     = count_r[1];
  assign rd_valid = count_r != 2'd0;
  assign rd_item  = slot_r[rd_ptr_r];
  assign push     = wr_valid && !full;
  assign pull     = rd_take && rd_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pull) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pull) begin
        count_r <= count_r + 2'd1;
      end else if (pull && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: rtl/uart_trx_back.sv
// Back engine: per-tick receiver, receive FIFO, transmitter, config registers
// and the registered result stage. Depends on uart_trx_pkg.
module uart_trx_back #(
  parameter int FIFO_DEPTH = uart_trx_pkg::FIFO_DEPTH_DEF,
  parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  logic                 bq_valid,
  output logic                 bq_take,
  input  uart_trx_pkg::tick_t  bq_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_tx_line,
  output logic                 out_tx_busy,
  output logic [7:0]           out_rx_data,
  output logic                 out_rx_data_valid,
  output logic [CNT_W-1:0]     out_rx_count,
  output logic                 out_parity_error,
  output logic                 out_overflow
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

  typedef enum logic [1:0] {PH_IDLE, PH_START, PH_BITS, PH_STOP} rx_phase_t;

  // Configuration
  logic [15:0] bit_period_r;
  logic [3:0]  data_bits_r;
  logic        parity_en_r;
  logic        two_stop_r;

  // Receiver state
  rx_phase_t   phase_r, phase_nxt;
  logic [15:0] rx_timer_r, rx_timer_nxt;
  logic [7:0]  rx_shift_r, rx_shift_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic        ones_r, ones_nxt;

  // FIFO state
  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       rd_data_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  // Transmitter state
  logic [11:0] tx_frame_r, tx_frame_nxt;
  logic [3:0]  bits_left_r, bits_left_nxt;
  logic [15:0] tx_timer_r, tx_timer_nxt;

  // Result stage
  logic             out_valid_r;
  logic             tx_line_r, tx_busy_r, popped_r, perr_r, ovf_r;
  logic [CNT_W-1:0] count_r;

  // Per-tick combinational terms
  logic [15:0]      period;
  logic [3:0]       nbits;
  logic             pop_ok;
  logic [CNT_W-1:0] fill_after_pop;
  logic [15:0]      rx_timer_dec;
  logic             push_req;
  logic             push_ok;
  logic             perr;
  logic             ovf;
  logic [7:0]       tx_mask;
  logic [7:0]       tx_bits;
  logic [3:0]       pos;
  logic [11:0]      frame_start;
  logic [11:0]      frame_cur;
  logic [3:0]       left_cur;
  logic [15:0]      tx_timer_cur;
  logic [15:0]      tx_timer_dec;
  logic             busy;
  logic             line_out;
  logic             advance;

  // Take the next tick whenever the result stage is free or drains
  assign advance = bq_valid && (!out_valid_r || !out_stall);
  assign bq_take = advance;

  // Effective period and character width
  assign period = (bit_period_r < uart_trx_pkg::MIN_PERIOD) ? uart_trx_pkg::MIN_PERIOD
                                                            : bit_period_r;
  assign nbits  = (data_bits_r < uart_trx_pkg::MIN_BITS) ? uart_trx_pkg::MIN_BITS :
                  (data_bits_r > uart_trx_pkg::MAX_BITS) ? uart_trx_pkg::MAX_BITS :
                  data_bits_r;

  // Serve a pop before the receiver pushes
  assign pop_ok         = bq_item.pop && (fill_r != '0);
  assign fill_after_pop = fill_r - CNT_W'(pop_ok);
  assign head_nxt       = !pop_ok ? head_r :
                          (head_r == LAST_PTR) ? '0 : head_r + PTR_W'(1);

  // Receiver: start detect, mid-bit sampling, parity check
  assign rx_timer_dec = (rx_timer_r != 16'd0) ? rx_timer_r - 16'd1 : rx_timer_r;

  always_comb begin
    phase_nxt    = phase_r;
    rx_timer_nxt = rx_timer_r;
    rx_shift_nxt = rx_shift_r;
    bit_idx_nxt  = bit_idx_r;
    ones_nxt     = ones_r;
    push_req     = 1'b0;
    perr         = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (!bq_item.rx_line) begin
        phase_nxt    = PH_START;
        rx_timer_nxt = period >> 1;
      end
    end else begin
      rx_timer_nxt = rx_timer_dec;
      if (rx_timer_dec == 16'd0) begin
        rx_timer_nxt = period;
        case (phase_r)
          PH_START: begin
            phase_nxt    = PH_BITS;
            bit_idx_nxt  = 4'd0;
            rx_shift_nxt = 8'd0;
            ones_nxt     = 1'b0;
          end
          PH_BITS: begin
            if (bit_idx_r < nbits) begin
              rx_shift_nxt = rx_shift_r | (8'(bq_item.rx_line) << bit_idx_r[2:0]);
              ones_nxt     = ones_r ^ bq_item.rx_line;
              bit_idx_nxt  = bit_idx_r + 4'd1;
              if ((bit_idx_r + 4'd1 >= nbits) && !parity_en_r) begin
                push_req  = 1'b1;
                phase_nxt = PH_STOP;
              end
            end else if (bq_item.rx_line == ones_r) begin
              push_req  = 1'b1;
              phase_nxt = PH_STOP;
            end else begin
              perr      = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // Push a finished character, or flag overflow when full
  assign push_ok  = push_req && (fill_after_pop < FULL_CNT);
  assign ovf      = push_req && !push_ok;
  assign fill_nxt = fill_after_pop + CNT_W'(push_ok);
  assign tail_nxt = !push_ok ? tail_r :
                    (tail_r == LAST_PTR) ? '0 : tail_r + PTR_W'(1);

  // Transmitter: build a frame on a send while idle, then shift one bit per period
  assign tx_mask = 8'hFF >> (4'd8 - nbits);
  assign tx_bits = bq_item.tx_data & tx_mask;

  always_comb begin
    frame_start = {3'b000, tx_bits, 1'b0};
    pos         = nbits + 4'd1;
    if (parity_en_r) begin
      frame_start = frame_start | (12'(^tx_bits) << pos);
      pos         = pos + 4'd1;
    end
    frame_start = frame_start | (12'hFFF << pos);
  end

  always_comb begin
    frame_cur    = tx_frame_r;
    left_cur     = bits_left_r;
    tx_timer_cur = tx_timer_r;
    if (bq_item.send && bits_left_r == 4'd0) begin
      frame_cur    = frame_start;
      left_cur     = pos + 4'd1 + 4'(two_stop_r);
      tx_timer_cur = period;
    end
  end

  assign busy         = left_cur != 4'd0;
  assign line_out     = busy ? frame_cur[0] : 1'b1;
  assign tx_timer_dec = (tx_timer_cur != 16'd0) ? tx_timer_cur - 16'd1 : tx_timer_cur;

  always_comb begin
    tx_frame_nxt  = frame_cur;
    bits_left_nxt = left_cur;
    tx_timer_nxt  = tx_timer_cur;
    if (busy) begin
      tx_timer_nxt = tx_timer_dec;
      if (tx_timer_dec == 16'd0) begin
        tx_frame_nxt  = {1'b1, frame_cur[11:1]};
        bits_left_nxt = left_cur - 4'd1;
        tx_timer_nxt  = period;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= uart_trx_pkg::BIT_PERIOD_RST;
      data_bits_r  <= uart_trx_pkg::DATA_BITS_RST;
      parity_en_r  <= 1'b0;
      two_stop_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        uart_trx_pkg::REG_BIT_PERIOD: bit_period_r <= cfg_wdata;
        uart_trx_pkg::REG_DATA_BITS:  data_bits_r  <= cfg_wdata[3:0];
        uart_trx_pkg::REG_PARITY_EN:  parity_en_r  <= cfg_wdata[0];
        uart_trx_pkg::REG_TWO_STOP:   two_stop_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Engine state and result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      rx_timer_r  <= 16'd0;
      rx_shift_r  <= 8'd0;
      bit_idx_r   <= 4'd0;
      ones_r      <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      tx_frame_r  <= 12'hFFF;
      bits_left_r <= 4'd0;
      tx_timer_r  <= 16'd0;
      out_valid_r <= 1'b0;
      tx_line_r   <= 1'b1;
      tx_busy_r   <= 1'b0;
      popped_r    <= 1'b0;
      count_r     <= '0;
      perr_r      <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      if (advance) begin
        phase_r     <= phase_nxt;
        rx_timer_r  <= rx_timer_nxt;
        rx_shift_r  <= rx_shift_nxt;
        bit_idx_r   <= bit_idx_nxt;
        ones_r      <= ones_nxt;
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        fill_r      <= fill_nxt;
        tx_frame_r  <= tx_frame_nxt;
        bits_left_r <= bits_left_nxt;
        tx_timer_r  <= tx_timer_nxt;
        out_valid_r <= 1'b1;
        tx_line_r   <= line_out;
        tx_busy_r   <= busy;
        popped_r    <= pop_ok;
        count_r     <= fill_nxt;
        perr_r      <= perr;
        ovf_r       <= ovf;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Receive FIFO storage with registered read at the head
  always_ff @(posedge clk) begin
    if (advance && push_ok) begin
      mem[tail_r] <= rx_shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tx_line       = tx_line_r;
  assign out_tx_busy       = tx_busy_r;
  assign out_rx_data       = popped_r ? rd_data_r : 8'd0;
  assign out_rx_data_valid = popped_r;
  assign out_rx_count      = count_r;
  assign out_parity_error  = perr_r;
  assign out_overflow      = ovf_r;

endmodule

FILE: rtl/uart_trx_checker.sv
// Port-level checker for the serial transceiver, bound to the top level.
// Depends on uart_trx_pkg for the default FIFO depth.
module uart_trx_checker #(
  parameter int FIFO_DEPTH = uart_trx_pkg::FIFO_DEPTH_DEF,
  parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_tx_line,
  input logic             out_tx_busy,
  input logic [7:0]       out_rx_data,
  input logic             out_rx_data_valid,
  input logic [CNT_W-1:0] out_rx_count,
  input logic             out_parity_error,
  input logic             out_overflow
);

  // Line idles high whenever no frame is on the wire
  a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_busy |-> out_tx_line)
    else $error("tx line low while transmitter idle");

  // Data reads zero unless a byte was popped
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rx_data_valid |-> out_rx_data == 8'd0)
    else $error("rx data nonzero without a pop");

  // Fill never exceeds the FIFO depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rx_count <= CNT_W'(FIFO_DEPTH))
    else $error("rx count above FIFO depth");

  // A character is dropped for one reason only
  a_one_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_parity_error && out_overflow))
    else $error("parity error and overflow on the same item");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rx_count) && $stable(out_tx_line))
    else $error("stalled result changed");

endmodule

bind uart_transceiver uart_trx_checker #(
  .FIFO_DEPTH (FIFO_DEPTH),
  .CNT_W      (CNT_W)
) u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_tx_line       (out_tx_line),
  .out_tx_busy       (out_tx_busy),
  .out_rx_data       (out_rx_data),
  .out_rx_data_valid (out_rx_data_valid),
  .out_rx_count      (out_rx_count),
  .out_parity_error  (out_parity_error),
  .out_overflow      (out_overflow)
);
